>>> rtl/core/spa_pkg.sv
`default_nettype none
package spa_pkg;

  // fixed frame offsets, fixed 20 byte ip header
  localparam logic [15:0] POS_ETH_HI    = 16'd12;
  localparam logic [15:0] POS_ETH_LO    = 16'd13;
  localparam logic [15:0] POS_PROTO     = 16'd23;
  localparam logic [15:0] POS_SRC_0     = 16'd26;
  localparam logic [15:0] POS_SRC_1     = 16'd27;
  localparam logic [15:0] POS_SRC_2     = 16'd28;
  localparam logic [15:0] POS_SRC_3     = 16'd29;
  localparam logic [15:0] POS_DPORT_HI  = 16'd36;
  localparam logic [15:0] POS_DPORT_LO  = 16'd37;
  localparam logic [15:0] POS_PAYLOAD   = 16'd42;
  localparam logic [15:0] POS_IP_END    = 16'd33;  // last byte of shortest ip frame
  localparam logic [15:0] POS_UDP_END   = 16'd41;  // last byte of shortest udp frame
  localparam logic [15:0] POS_MAX       = 16'hFFFF;
  localparam logic [15:0] ETHERTYPE_IP4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [15:0] MAGIC_PORT_RST = 16'd1337;
  localparam logic [31:0] CNT_MAX       = 32'hFFFF_FFFF;

  localparam int unsigned TOKEN_TABLE_SIZE = 64;
  localparam logic [7:0] TOKEN_BYTES [TOKEN_TABLE_SIZE] = '{
    0: 8'h50, 1: 8'h48, 2: 8'h41, 3: 8'h4E, 4: 8'h54, 5: 8'h4F, 6: 8'h4D,
    7: 8'h5F, 8: 8'h47, 9: 8'h52, 10: 8'h49, 11: 8'h44, 12: 8'h5F,
    13: 8'h53, 14: 8'h50, 15: 8'h41, 16: 8'h5F, 17: 8'h32, 18: 8'h30,
    19: 8'h32, 20: 8'h35, default: 8'h00
  };

  typedef enum logic [2:0] {
    RSN_PASS_SHORT  = 3'd0,
    RSN_SHORT_UDP   = 3'd1,
    RSN_AUTH_OK     = 3'd2,
    RSN_AUTH_FAIL   = 3'd3,
    RSN_WHITELISTED = 3'd4,
    RSN_UNKNOWN     = 3'd5
  } reason_e;

  typedef enum logic [1:0] {
    JOB_DIRECT = 2'd0,
    JOB_LOOKUP = 2'd1,
    JOB_INSERT = 2'd2
  } job_e;

  typedef enum logic [1:0] {
    B_IDLE   = 2'd0,
    B_SCAN   = 2'd1,
    B_UPDATE = 2'd2,
    B_EMIT   = 2'd3
  } back_state_e;

  typedef struct packed {
    job_e        kind;
    logic        verdict;
    reason_e     reason;
    logic [31:0] src;
    logic [31:0] succ;
    logic [31:0] fail;
  } spa_job_t;

endpackage
`default_nettype wire

>>> rtl/core/spa_in_if.sv
`default_nettype none
interface spa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pkt_byte;
  logic       last_byte;
  modport source (output valid, pkt_byte, last_byte, input ready);
  modport sink (input valid, pkt_byte, last_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/core/spa_out_if.sv
`default_nettype none
interface spa_out_if;
  logic        valid;
  logic        ready;
  logic        verdict;
  logic [2:0]  decision_reason;
  logic [31:0] source_address;
  logic [31:0] success_total;
  logic [31:0] failure_total;
  modport source (output valid, verdict, decision_reason, source_address, success_total,
                  failure_total, input ready);
  modport sink (input valid, verdict, decision_reason, source_address, success_total,
                failure_total, output ready);
endinterface
`default_nettype wire

>>> rtl/core/spa_ram.sv
`default_nettype none
module spa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/spa_front.sv
`default_nettype none
module spa_front import spa_pkg::*; #(
  parameter int unsigned TOKEN_LENGTH = 21
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  spa_in_if.sink        pkt_i,
  input  wire logic     cfg_we_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic     q_full_i,
  output logic          q_push_o,
  output spa_job_t      q_data_o
);
  localparam logic [15:0] TOK_END = 16'(42 + TOKEN_LENGTH);

  logic [15:0] magic_q;
  logic [15:0] pos_q, eth_q, eth_d, dport_q, dport_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d, succ_q, succ_d, fail_q, fail_d;
  logic        tok_q, tok_d;
  logic        accept;
  logic [7:0]  b;
  logic [5:0]  tok_idx;
  spa_job_t    job;

  assign pkt_i.ready = !q_full_i;
  assign accept      = pkt_i.valid && pkt_i.ready;
  assign b           = pkt_i.pkt_byte;
  assign tok_idx     = 6'(pos_q - POS_PAYLOAD);

  // absorb the current byte
  always_comb begin
    eth_d   = eth_q;
    proto_d = proto_q;
    src_d   = src_q;
    dport_d = dport_q;
    tok_d   = tok_q;
    if (pos_q == POS_ETH_HI || pos_q == POS_ETH_LO) begin
      eth_d = {eth_q[7:0], b};
    end else if (pos_q == POS_PROTO) begin
      proto_d = b;
    end else if (pos_q == POS_SRC_0) begin
      src_d[31:24] = b;
    end else if (pos_q == POS_SRC_1) begin
      src_d[23:16] = b;
    end else if (pos_q == POS_SRC_2) begin
      src_d[15:8] = b;
    end else if (pos_q == POS_SRC_3) begin
      src_d[7:0] = b;
    end else if (pos_q == POS_DPORT_HI || pos_q == POS_DPORT_LO) begin
      dport_d = {dport_q[7:0], b};
    end else if (pos_q >= POS_PAYLOAD && pos_q < TOK_END) begin
      if (b != TOKEN_BYTES[tok_idx]) tok_d = 1'b0;
    end
  end

  // classify on the last byte
  always_comb begin
    succ_d      = succ_q;
    fail_d      = fail_q;
    job.kind    = JOB_DIRECT;
    job.verdict = 1'b0;
    job.reason  = RSN_PASS_SHORT;
    if (pos_q < POS_IP_END || eth_d != ETHERTYPE_IP4) begin
      job.kind = JOB_DIRECT;
    end else if (proto_d == PROTO_UDP && pos_q < POS_UDP_END) begin
      job.verdict = 1'b1;
      job.reason  = RSN_SHORT_UDP;
    end else if (proto_d == PROTO_UDP && dport_d == magic_q) begin
      job.verdict = 1'b1;
      if (pos_q >= TOK_END - 16'd1 && tok_d) begin
        job.kind   = JOB_INSERT;
        job.reason = RSN_AUTH_OK;
        if (succ_q != CNT_MAX) succ_d = succ_q + 32'd1;
      end else begin
        job.reason = RSN_AUTH_FAIL;
        if (fail_q != CNT_MAX) fail_d = fail_q + 32'd1;
      end
    end else begin
      job.kind    = JOB_LOOKUP;
      job.verdict = 1'b1;
      job.reason  = RSN_UNKNOWN;
    end
    job.src  = src_d;
    job.succ = succ_d;
    job.fail = fail_d;
  end

  assign q_push_o = accept && pkt_i.last_byte;
  assign q_data_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= MAGIC_PORT_RST;
      pos_q   <= '0;
      eth_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dport_q <= '0;
      tok_q   <= 1'b1;
      succ_q  <= '0;
      fail_q  <= '0;
    end else begin
      if (cfg_we_i) magic_q <= cfg_data_i;
      if (accept) begin
        if (pkt_i.last_byte) begin
          pos_q   <= '0;
          eth_q   <= '0;
          proto_q <= '0;
          src_q   <= '0;
          dport_q <= '0;
          tok_q   <= 1'b1;
          succ_q  <= succ_d;
          fail_q  <= fail_d;
        end else begin
          if (pos_q != POS_MAX) pos_q <= pos_q + 16'd1;
          eth_q   <= eth_d;
          proto_q <= proto_d;
          src_q   <= src_d;
          dport_q <= dport_d;
          tok_q   <= tok_d;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/spa_fifo.sv
`default_nettype none
module spa_fifo import spa_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire spa_job_t data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output spa_job_t      data_o,
  output logic          empty_o
);
  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW = $clog2(DEPTH);

  spa_job_t      mem_q [DEPTH];
  logic [PW:0]   wr_q, rd_q;

  assign full_o  = (wr_q[PW] != rd_q[PW]) && (wr_q[PW-1:0] == rd_q[PW-1:0]);
  assign empty_o = (wr_q == rd_q);
  assign data_o  = mem_q[rd_q[PW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q[PW-1:0]] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i && !full_o) wr_q <= wr_q + 1'b1;
      if (pop_i && !empty_o) rd_q <= rd_q + 1'b1;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/spa_back.sv
`default_nettype none
module spa_back import spa_pkg::*; #(
  parameter int unsigned WHITELIST_DEPTH = 128
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     q_empty_i,
  input  wire spa_job_t q_data_i,
  output logic          q_pop_o,
  spa_out_if.source     res_o
);
  localparam int unsigned D  = WHITELIST_DEPTH;
  localparam int unsigned IW = (D > 1) ? $clog2(D) : 1;
  localparam int unsigned CW = $clog2(D + 1);
  localparam logic [CW-1:0] CNT_END = CW'(D);
  localparam logic [IW-1:0] IDX_LAST = IW'(D - 1);

  back_state_e   state_q, state_d;
  spa_job_t      job_q, job_d;
  logic [CW-1:0] issue_q, issue_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          cmp_vld_q;
  logic [IW-1:0] cmp_idx_q;
  logic          found_q;
  logic [IW-1:0] found_idx_q, found_age_q, old_idx_q, old_age_q;
  logic [31:0]   addr_rd;
  logic [IW-1:0] age_rd;
  logic          cmp_live;
  logic          sweep_last;
  logic          addr_we;
  logic [IW-1:0] addr_wa;
  logic          age_we;
  logic [IW-1:0] age_wd;
  logic          do_touch, touch_all;
  logic [IW-1:0] tgt, lim;
  logic          load_out;
  logic          out_valid_q;
  logic          verdict_q;
  reason_e       reason_q;
  logic [31:0]   src_q, succ_q, fail_q;

  spa_ram #(.WIDTH(32), .DEPTH(D)) u_addr_ram (
    .clk_i,
    .wr_en_i   (addr_we),
    .wr_addr_i (addr_wa),
    .wr_data_i (job_q.src),
    .rd_en_i   (state_q == B_SCAN),
    .rd_addr_i (issue_q[IW-1:0]),
    .rd_data_o (addr_rd)
  );

  // recency ranks, 0 is the most recent
  spa_ram #(.WIDTH(IW), .DEPTH(D)) u_age_ram (
    .clk_i,
    .wr_en_i   (age_we),
    .wr_addr_i (cmp_idx_q),
    .wr_data_i (age_wd),
    .rd_en_i   (state_q == B_SCAN || state_q == B_UPDATE),
    .rd_addr_i (issue_q[IW-1:0]),
    .rd_data_o (age_rd)
  );

  // entries fill from slot 0 upwards and are never freed
  assign cmp_live   = cmp_vld_q && (CW'(cmp_idx_q) < fill_q);
  assign sweep_last = cmp_vld_q && (cmp_idx_q == IDX_LAST);
  assign load_out   = (state_q == B_EMIT) && (!out_valid_q || res_o.ready);

  // touch plan, stable once the scan has finished
  always_comb begin
    do_touch  = 1'b0;
    touch_all = 1'b0;
    tgt       = found_idx_q;
    lim       = found_age_q;
    addr_wa   = fill_q[IW-1:0];
    if (found_q) begin
      do_touch = 1'b1;
    end else if (job_q.kind == JOB_INSERT) begin
      do_touch = 1'b1;
      if (fill_q != CNT_END) begin
        tgt       = fill_q[IW-1:0];
        touch_all = 1'b1;
      end else begin
        tgt     = old_idx_q;
        lim     = old_age_q;
        addr_wa = old_idx_q;
      end
    end
  end

  // age write back during the update sweep
  always_comb begin
    age_we = 1'b0;
    age_wd = '0;
    if (state_q == B_UPDATE && cmp_vld_q) begin
      if (cmp_idx_q == tgt) begin
        age_we = 1'b1;
      end else if (cmp_live && (touch_all || age_rd < lim)) begin
        age_we = 1'b1;
        age_wd = age_rd + 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    issue_d = issue_q;
    fill_d  = fill_q;
    q_pop_o = 1'b0;
    addr_we = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          job_d   = q_data_i;
          issue_d = '0;
          state_d = (q_data_i.kind == JOB_DIRECT) ? B_EMIT : B_SCAN;
        end
      end
      B_SCAN: begin
        if (issue_q != CNT_END) issue_d = issue_q + 1'b1;
        if (sweep_last) begin
          state_d = B_UPDATE;
          issue_d = '0;
        end
      end
      B_UPDATE: begin
        if (found_q && job_q.kind == JOB_LOOKUP) begin
          job_d.verdict = 1'b0;
          job_d.reason  = RSN_WHITELISTED;
        end
        if (issue_q != CNT_END) issue_d = issue_q + 1'b1;
        if (!do_touch) begin
          state_d = B_EMIT;
        end else if (sweep_last) begin
          state_d = B_EMIT;
          if (!found_q) begin
            addr_we = 1'b1;
            if (fill_q != CNT_END) fill_d = fill_q + 1'b1;
          end
        end
      end
      B_EMIT: begin
        if (load_out) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (load_out) begin
      verdict_q <= job_q.verdict;
      reason_q  <= job_q.reason;
      src_q     <= job_q.src;
      succ_q    <= job_q.succ;
      fail_q    <= job_q.fail;
    end
    if (state_q == B_SCAN && cmp_vld_q) begin
      if (!found_q && cmp_live && addr_rd == job_q.src) begin
        found_q     <= 1'b1;
        found_idx_q <= cmp_idx_q;
        found_age_q <= age_rd;
      end
      if (cmp_idx_q == '0 || age_rd > old_age_q) begin
        old_idx_q <= cmp_idx_q;
        old_age_q <= age_rd;
      end
    end
    if (state_q == B_IDLE) begin
      found_q <= 1'b0;
    end
    cmp_idx_q <= issue_q[IW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      issue_q     <= '0;
      fill_q      <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      issue_q   <= issue_d;
      fill_q    <= fill_d;
      cmp_vld_q <= (state_q == B_SCAN || state_q == B_UPDATE) && (issue_q != CNT_END);
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.verdict         = verdict_q;
  assign res_o.decision_reason = reason_q;
  assign res_o.source_address  = src_q;
  assign res_o.success_total   = succ_q;
  assign res_o.failure_total   = fail_q;

`ifndef SYNTH
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SCAN) |-> (issue_q <= CNT_END))
    else $error("scan counter overran the whitelist");
  a_update_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_UPDATE) |=> (state_q == B_UPDATE || state_q == B_EMIT))
    else $error("update left for a state other than emit");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_END)
    else $error("whitelist fill count overran");
  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == B_EMIT))
    else $error("result raised outside emit");
`endif
endmodule
`default_nettype wire

>>> rtl/core/spa_packet_filter_whitelist.sv
`default_nettype none
// channel   dir  width             transaction
// pkt_i     in   8 + 1             one frame byte, last_byte flags frame end
// res_o     out  1 + 3 + 32*3      one verdict per frame
// cfg       in   16                magic port write, no handshake
//
// bytes are taken one per cycle while the job queue has room
// a whitelist miss costs the back end the ram sweep for the search, a hit or an insert
// also the ram sweep for the age update; direct jobs skip both sweeps
// reset clears parser, counters and the whitelist fill count at once, no clearing pass
// result register lets the back end finish while the sink stalls
module spa_packet_filter_whitelist import spa_pkg::*; #(
  parameter int unsigned WHITELIST_DEPTH = 128,
  parameter int unsigned TOKEN_LENGTH = 21
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  spa_in_if.sink           pkt_i,
  spa_out_if.source        res_o,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_data_i
);
  // queue of classified frames between parser and whitelist engine
  logic     q_push, q_full, q_pop, q_empty;
  spa_job_t q_wdata, q_rdata;

  // byte parser, counters and magic port live here
  spa_front #(.TOKEN_LENGTH(TOKEN_LENGTH)) u_front (
    .clk_i,
    .rst_ni,
    .pkt_i,
    .cfg_we_i,
    .cfg_data_i,
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  spa_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // lru whitelist search and update, owns the result register
  spa_back #(.WHITELIST_DEPTH(WHITELIST_DEPTH)) u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .res_o
  );
endmodule
`default_nettype wire

>>> tb/tb_spa_packet_filter_whitelist.sv
`timescale 1ns / 100ps
module tb_spa_packet_filter_whitelist;
  import spa_pkg::*;

  // block geometry, kept in step with the instance below
  localparam int unsigned WL_DEPTH   = 128;
  localparam int unsigned TOKEN_LEN  = 21;
  // a frame can sit in the back end for about two full ram sweeps
  localparam int unsigned DRAIN_WAIT = 2 * WL_DEPTH + 16;
  localparam int unsigned RAND_BYTES = 640;

  // kinds of frame the generator can build
  typedef enum int {
    FR_RAW,       // random bytes, nothing forced
    FR_NONIP,     // ethertype forced away from ipv4
    FR_TCP,       // ipv4, protocol 6
    FR_UDP,       // ipv4 udp to a port that is not the magic one
    FR_AUTH_OK,   // udp to the magic port carrying the right token
    FR_AUTH_BAD   // udp to the magic port with one token byte spoilt
  } frame_kind_e;

  typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_e;

  typedef struct {
    frame_kind_e kind;
    int          len;
    logic [31:0] src;
    fill_e       fill;
    bit          typed;    // verdict and reason typed in below
    logic        verdict;
    reason_e     reason;
  } stim_row_t;

  typedef struct {
    logic        verdict;
    reason_e     reason;
    logic [31:0] src;
    logic [31:0] succ;
    logic [31:0] fail;
  } verdict_t;

  logic clk_i;
  logic rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_data_i;

  spa_in_if  pkt_if ();
  spa_out_if res_if ();

  spa_packet_filter_whitelist #(
    .WHITELIST_DEPTH (WL_DEPTH),
    .TOKEN_LENGTH    (TOKEN_LEN)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pkt_i      (pkt_if.sink),
    .res_o      (res_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // predictor state: parser, whitelist with lru ranks, counters, magic port
  // ---------------------------------------------------------------------------
  logic [15:0] magic_port_q;
  logic [15:0] frame_pos;
  logic [15:0] frame_ethertype;
  logic [7:0]  frame_proto;
  logic [31:0] frame_src;
  logic [15:0] frame_dport;
  bit          frame_token_ok;
  logic [31:0] wl_addr [WL_DEPTH];
  bit          wl_valid [WL_DEPTH];
  int unsigned wl_rank [WL_DEPTH];
  logic [31:0] auth_ok_count;
  logic [31:0] auth_fail_count;

  verdict_t    verdicts_due[$];
  int unsigned err_count;
  int unsigned verdicts_seen;
  int unsigned bytes_sent;
  int unsigned reason_hist [6];
  bit          no_idle;      // stretches with both sides running flat out

  // frame scratch shared by the builder and the sender
  logic [7:0] frame_bytes[$];

  function automatic void restart_frame();
    frame_pos       = '0;
    frame_ethertype = '0;
    frame_proto     = '0;
    frame_src       = '0;
    frame_dport     = '0;
    frame_token_ok  = 1'b1;
  endfunction

  function automatic int lookup_source(input logic [31:0] addr);
    for (int i = 0; i < WL_DEPTH; i++)
      if (wl_valid[i] && wl_addr[i] == addr) return i;
    return -1;
  endfunction

  // slot becomes most recent, everything younger than limit ages by one
  function automatic void promote_slot(input int slot, input longint unsigned limit);
    for (int i = 0; i < WL_DEPTH; i++)
      if (i != slot && wl_valid[i] && wl_rank[i] < limit) wl_rank[i]++;
    wl_valid[slot] = 1'b1;
    wl_rank[slot]  = 0;
  endfunction

  function automatic void admit_source(input logic [31:0] addr);
    int slot;
    slot = lookup_source(addr);
    if (slot >= 0) begin
      promote_slot(slot, wl_rank[slot]);
      return;
    end
    for (int i = 0; i < WL_DEPTH; i++) begin
      if (!wl_valid[i]) begin
        wl_addr[i] = addr;
        promote_slot(i, 64'hFFFF_FFFF);
        return;
      end
    end
    // full list: the oldest entry gives way
    slot = 0;
    for (int i = 1; i < WL_DEPTH; i++)
      if (wl_rank[i] > wl_rank[slot]) slot = i;
    wl_addr[slot] = addr;
    promote_slot(slot, wl_rank[slot]);
  endfunction

  // one accepted byte in, returns 1 with the verdict when the frame closes
  function automatic bit judge_byte(input logic [7:0] b, input logic last,
                                    output verdict_t v);
    int unsigned pos;
    int unsigned flen;
    int          slot;
    pos = frame_pos;
    if (pos == 12 || pos == 13)
      frame_ethertype = {frame_ethertype[7:0], b};
    else if (pos == 23)
      frame_proto = b;
    else if (pos >= 26 && pos <= 29)
      frame_src = frame_src | (32'(b) << (8 * (29 - pos)));
    else if (pos == 36 || pos == 37)
      frame_dport = {frame_dport[7:0], b};
    else if (pos >= 42 && pos < 42 + TOKEN_LEN) begin
      if (b != TOKEN_BYTES[(pos - 42) % TOKEN_TABLE_SIZE]) frame_token_ok = 1'b0;
    end
    if (!last) begin
      if (frame_pos != POS_MAX) frame_pos = frame_pos + 16'd1;
      return 1'b0;
    end
    flen = pos + 1;
    if (flen < 34 || frame_ethertype != ETHERTYPE_IP4) begin
      v.verdict = 1'b0;
      v.reason  = RSN_PASS_SHORT;
    end else if (frame_proto == PROTO_UDP && flen < 42) begin
      v.verdict = 1'b1;
      v.reason  = RSN_SHORT_UDP;
    end else if (frame_proto == PROTO_UDP && frame_dport == magic_port_q) begin
      v.verdict = 1'b1;
      if (flen >= 42 + TOKEN_LEN && frame_token_ok) begin
        admit_source(frame_src);
        if (auth_ok_count != CNT_MAX) auth_ok_count++;
        v.reason = RSN_AUTH_OK;
      end else begin
        if (auth_fail_count != CNT_MAX) auth_fail_count++;
        v.reason = RSN_AUTH_FAIL;
      end
    end else begin
      slot = lookup_source(frame_src);
      if (slot >= 0) begin
        promote_slot(slot, wl_rank[slot]);
        v.verdict = 1'b0;
        v.reason  = RSN_WHITELISTED;
      end else begin
        v.verdict = 1'b1;
        v.reason  = RSN_UNKNOWN;
      end
    end
    v.src  = frame_src;
    v.succ = auth_ok_count;
    v.fail = auth_fail_count;
    restart_frame();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // ---------------------------------------------------------------------------
  // frame builder
  // ---------------------------------------------------------------------------
  function automatic void build_frame(input frame_kind_e kind, input int len,
                                      input logic [31:0] src, input fill_e fill,
                                      input logic [15:0] dport);
    logic [7:0] b;
    int         spoil;
    frame_bytes.delete();
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom);
      endcase
      frame_bytes.push_back(b);
    end
    if (kind == FR_RAW) return;
    if (kind == FR_NONIP) begin
      // any ethertype but ipv4
      if (len > 13 && {frame_bytes[12], frame_bytes[13]} == ETHERTYPE_IP4) frame_bytes[13] = 8'h06;
      return;
    end
    if (len > 12) frame_bytes[12] = ETHERTYPE_IP4[15:8];
    if (len > 13) frame_bytes[13] = ETHERTYPE_IP4[7:0];
    if (len > 23) frame_bytes[23] = (kind == FR_TCP) ? 8'd6 : PROTO_UDP;
    for (int i = 0; i < 4; i++)
      if (len > 26 + i) frame_bytes[26 + i] = src[31 - 8 * i -: 8];
    if (len > 36) frame_bytes[36] = dport[15:8];
    if (len > 37) frame_bytes[37] = dport[7:0];
    if (kind == FR_AUTH_OK || kind == FR_AUTH_BAD) begin
      for (int i = 0; i < TOKEN_LEN; i++)
        if (len > 42 + i) frame_bytes[42 + i] = TOKEN_BYTES[i];
      if (kind == FR_AUTH_BAD) begin
        spoil = $urandom_range(TOKEN_LEN - 1);
        if (len > 42 + spoil)
          frame_bytes[42 + spoil] = TOKEN_BYTES[spoil] ^ 8'($urandom_range(255, 1));
      end
    end
  endfunction

  // port that goes with a kind under the current magic port
  function automatic logic [15:0] port_for(input frame_kind_e kind);
    logic [15:0] p;
    if (kind == FR_AUTH_OK || kind == FR_AUTH_BAD) return magic_port_q;
    p = 16'($urandom);
    if (p == magic_port_q) p = ~p;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // byte sender: drive on the falling edge, predict on the accepting edge
  // ---------------------------------------------------------------------------
  task automatic send_frame();
    verdict_t   v;
    int unsigned gap;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      gap = pick_gap();
      if (gap != 0) begin
        pkt_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pkt_if.valid     = 1'b1;
      pkt_if.pkt_byte  = frame_bytes[i];
      pkt_if.last_byte = (i == frame_bytes.size() - 1);
      do @(posedge clk_i); while (!pkt_if.ready);
      bytes_sent++;
      if (judge_byte(frame_bytes[i], pkt_if.last_byte, v)) verdicts_due.push_back(v);
      @(negedge clk_i);
    end
    pkt_if.valid = 1'b0;
  endtask

  task automatic send_kind(input frame_kind_e kind, input int len,
                           input logic [31:0] src, input fill_e fill);
    build_frame(kind, len, src, fill, port_for(kind));
    send_frame();
  endtask

  // register writes only with the block drained
  task automatic write_magic_port(input logic [15:0] port);
    while (verdicts_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = port;
    @(posedge clk_i);
    magic_port_q = port;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // verdict checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      verdicts_seen++;
      if (verdicts_due.size() == 0) begin
        err_count++;
        $display("%0t verdict with no frame outstanding", $realtime);
      end else begin
        want = verdicts_due.pop_front();
        if (res_if.decision_reason <= 3'd5) reason_hist[res_if.decision_reason]++;
        if (res_if.verdict !== want.verdict)
          report_mismatch("verdict", 32'(res_if.verdict), 32'(want.verdict));
        if (res_if.decision_reason !== want.reason)
          report_mismatch("decision_reason", 32'(res_if.decision_reason), 32'(want.reason));
        if (res_if.source_address !== want.src)
          report_mismatch("source_address", res_if.source_address, want.src);
        if (res_if.success_total !== want.succ)
          report_mismatch("success_total", res_if.success_total, want.succ);
        if (res_if.failure_total !== want.fail)
          report_mismatch("failure_total", res_if.failure_total, want.fail);
      end
    end
  end

  // sink side stalls
  initial begin
    int unsigned stall;
    stall = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall != 0) begin
        res_if.ready = 1'b0;
        stall--;
      end else begin
        res_if.ready = 1'b1;
        if ($urandom_range(99) < 20) stall = pick_gap();
      end
    end
  end

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // guard against a hung handshake
  initial begin
    #20ms;
    $display("timeout with %0d verdicts outstanding", verdicts_due.size());
    $display("spa_packet_filter_whitelist test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  localparam logic [31:0] HOST_A = 32'hC0A8_0101;

  // directed frames; verdicts typed in where they are plain to see
  stim_row_t directed [] = '{
    '{FR_RAW,      1, 32'h0,        FILL_RAND, 1, 1'b0, RSN_PASS_SHORT},
    '{FR_UDP,     33, HOST_A,       FILL_RAND, 1, 1'b0, RSN_PASS_SHORT},
    '{FR_NONIP,   60, HOST_A,       FILL_RAND, 1, 1'b0, RSN_PASS_SHORT},
    '{FR_NONIP,   14, HOST_A,       FILL_ONES, 1, 1'b0, RSN_PASS_SHORT},
    '{FR_RAW,     70, 32'h0,        FILL_ZERO, 1, 1'b0, RSN_PASS_SHORT},
    '{FR_UDP,     34, HOST_A,       FILL_RAND, 1, 1'b1, RSN_SHORT_UDP},
    '{FR_AUTH_OK, 41, HOST_A,       FILL_RAND, 1, 1'b1, RSN_SHORT_UDP},
    '{FR_TCP,     40, HOST_A,       FILL_RAND, 1, 1'b1, RSN_UNKNOWN},
    '{FR_AUTH_OK, 63, HOST_A,       FILL_RAND, 1, 1'b1, RSN_AUTH_OK},
    '{FR_TCP,     34, HOST_A,       FILL_ONES, 1, 1'b0, RSN_WHITELISTED},
    '{FR_AUTH_OK, 62, HOST_A,       FILL_RAND, 1, 1'b1, RSN_AUTH_FAIL},
    '{FR_AUTH_BAD, 63, HOST_A,      FILL_RAND, 1, 1'b1, RSN_AUTH_FAIL},
    '{FR_AUTH_OK, 42, HOST_A,       FILL_ZERO, 1, 1'b1, RSN_AUTH_FAIL},
    '{FR_UDP,     42, HOST_A,       FILL_RAND, 1, 1'b0, RSN_WHITELISTED},
    '{FR_AUTH_OK, 63, 32'h0,        FILL_ZERO, 0, 1'b0, RSN_PASS_SHORT},
    '{FR_AUTH_OK, 80, 32'hFFFF_FFFF, FILL_ONES, 0, 1'b0, RSN_PASS_SHORT},
    '{FR_UDP,     50, 32'h0,        FILL_RAND, 1, 1'b0, RSN_WHITELISTED},
    '{FR_TCP,    300, 32'hFFFF_FFFF, FILL_RAND, 1, 1'b0, RSN_WHITELISTED},
    '{FR_AUTH_OK, 100, HOST_A,      FILL_RAND, 0, 1'b0, RSN_PASS_SHORT},
    '{FR_TCP,     45, 32'h0A00_0001, FILL_RAND, 1, 1'b1, RSN_UNKNOWN}
  };

  // small address pool so that lookups hit often
  logic [31:0] host_pool [8];

  function automatic logic [31:0] pick_host();
    if ($urandom_range(99) < 85) return host_pool[$urandom_range(7)];
    return 32'($urandom);
  endfunction

  task automatic random_stretch(input int unsigned budget);
    int unsigned stop_at;
    int unsigned r;
    frame_kind_e kind;
    int          len;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 25)      kind = FR_AUTH_OK;
      else if (r < 35) kind = FR_AUTH_BAD;
      else if (r < 55) kind = FR_TCP;
      else if (r < 75) kind = FR_UDP;
      else if (r < 85) kind = FR_NONIP;
      else             kind = FR_RAW;
      // mostly just long enough to matter, sometimes short or long
      r = $urandom_range(99);
      if (r < 15)      len = $urandom_range(41, 1);
      else if (r < 90) len = $urandom_range(70, 60);
      else             len = $urandom_range(200, 71);
      send_kind(kind, len, pick_host(), FILL_RAND);
      if ($urandom_range(99) < 10) no_idle = ~no_idle;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    verdict_t peek;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_data_i       = '0;
    pkt_if.valid     = 1'b0;
    pkt_if.pkt_byte  = '0;
    pkt_if.last_byte = 1'b0;
    err_count        = 0;
    verdicts_seen    = 0;
    bytes_sent       = 0;
    no_idle          = 1'b0;
    foreach (reason_hist[i]) reason_hist[i] = 0;
    magic_port_q    = MAGIC_PORT_RST;
    auth_ok_count   = '0;
    auth_fail_count = '0;
    for (int i = 0; i < WL_DEPTH; i++) begin
      wl_addr[i]  = '0;
      wl_valid[i] = 1'b0;
      wl_rank[i]  = 0;
    end
    restart_frame();
    foreach (host_pool[i]) host_pool[i] = 32'($urandom);
    host_pool[0] = 32'h0;
    host_pool[1] = 32'hFFFF_FFFF;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part under the reset magic port
    foreach (directed[i]) begin
      build_frame(directed[i].kind, directed[i].len, directed[i].src, directed[i].fill,
                  port_for(directed[i].kind));
      send_frame();
      if (directed[i].typed) begin
        peek = verdicts_due[$];
        if (peek.verdict !== directed[i].verdict || peek.reason !== directed[i].reason) begin
          err_count++;
          $display("directed frame %0d: predictor gives %0d/%0d, table says %0d/%0d", i,
                   peek.verdict, peek.reason, directed[i].verdict, directed[i].reason);
        end
      end
    end

    // random part across several magic port settings, extremes included
    write_magic_port(16'h0000);
    random_stretch(RAND_BYTES / 4);
    write_magic_port(16'hFFFF);
    random_stretch(RAND_BYTES / 4);
    write_magic_port(16'($urandom));
    random_stretch(RAND_BYTES / 4);
    write_magic_port(MAGIC_PORT_RST);
    random_stretch(RAND_BYTES / 4);

    // drain
    while (verdicts_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    $display("%0d bytes sent, %0d verdicts checked, %0d auth ok, %0d auth fail",
             bytes_sent, verdicts_seen, auth_ok_count, auth_fail_count);
    $display("reasons seen: short %0d, short udp %0d, ok %0d, fail %0d, listed %0d, unknown %0d",
             reason_hist[0], reason_hist[1], reason_hist[2], reason_hist[3], reason_hist[4],
             reason_hist[5]);
    if (err_count == 0 && verdicts_due.size() == 0) begin
      $display("spa_packet_filter_whitelist test passed");
    end else begin
      $display("spa_packet_filter_whitelist test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/spa_pkg.sv
rtl/core/spa_in_if.sv
rtl/core/spa_out_if.sv
rtl/core/spa_ram.sv
rtl/core/spa_front.sv
rtl/core/spa_fifo.sv
rtl/core/spa_back.sv
rtl/core/spa_packet_filter_whitelist.sv
tb/tb_spa_packet_filter_whitelist.sv
